[rtl/hpig_pkg.sv]
// Package for the hashed projection index generator.
// Holds hash constants, controller states and the command/status structs.
// No dependencies.
package hpig_pkg;

    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX1     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX2     = 64'h94d049bb133111eb;
    localparam logic [63:0] KEY_SALT = 64'hDEADBEEFF00DBABE;

    localparam int CFG_IW = 8;

    localparam logic [CFG_IW-1:0] REG_DIM    = 8'd0;
    localparam logic [CFG_IW-1:0] REG_SEED   = 8'd1;
    localparam logic [CFG_IW-1:0] REG_PROJ   = 8'd2;
    localparam logic [CFG_IW-1:0] REG_UNIQUE = 8'd3;

    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;
    localparam logic [1:0] SIGN_ZERO = 2'b00;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_KEY,
        OP_ADD_GOLD,
        OP_XS30,
        OP_XS27,
        OP_XS31,
        OP_MUL_LL,
        OP_MUL_HL,
        OP_MUL_LH,
        OP_MUL_FIN,
        OP_SAVE_BASE,
        OP_LOAD_PROJ,
        OP_SCALE_HI,
        OP_SCALE_LO,
        OP_SCALE_FIN,
        OP_PROBE_INIT,
        OP_PROBE_READ,
        OP_PROBE_BUMP,
        OP_PROBE_NEXT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mix_sel;   // 0: MIX1, 1: MIX2
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic probe_last;
        logic att_done;
        logic proj_last;
        logic t_zero;
        logic k_zero;
        logic d_zero;
        logic uniq_mode;
        logic out_free;
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADDG,
        S_XS30,
        S_M1_LL,
        S_M1_HL,
        S_M1_LH,
        S_M1_FIN,
        S_XS27,
        S_M2_LL,
        S_M2_HL,
        S_M2_LH,
        S_M2_FIN,
        S_XS31,
        S_MIXED,
        S_PLOAD,
        S_SC_HI,
        S_SC_LO,
        S_SC_FIN,
        S_PINIT,
        S_PRD,
        S_PCMP,
        S_EMIT
    } t_state;

endpackage

[rtl/hpig_ctrl.sv]
// Controller for the hashed projection index generator.
// Sequences the shared multiplier, scaling, probing and result beats.
// Depends on hpig_pkg.
module hpig_ctrl import hpig_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;
    logic   r_is_base, n_is_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_base <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_base <= n_is_base;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_base  = r_is_base;
        o_cmd.op      = OP_NONE;
        o_cmd.mix_sel = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op  = OP_LOAD_KEY;
                    n_is_base = 1'b1;
                    n_state   = S_ADDG;
                end
            end
            S_ADDG:   begin o_cmd.op = OP_ADD_GOLD; n_state = S_XS30; end
            S_XS30:   begin o_cmd.op = OP_XS30;     n_state = S_M1_LL; end
            S_M1_LL:  begin o_cmd.op = OP_MUL_LL;   n_state = S_M1_HL; end
            S_M1_HL:  begin o_cmd.op = OP_MUL_HL;   n_state = S_M1_LH; end
            S_M1_LH:  begin o_cmd.op = OP_MUL_LH;   n_state = S_M1_FIN; end
            S_M1_FIN: begin o_cmd.op = OP_MUL_FIN;  n_state = S_XS27; end
            S_XS27:   begin o_cmd.op = OP_XS27;     n_state = S_M2_LL; end
            S_M2_LL: begin
                o_cmd.op = OP_MUL_LL; o_cmd.mix_sel = 1'b1; n_state = S_M2_HL;
            end
            S_M2_HL: begin
                o_cmd.op = OP_MUL_HL; o_cmd.mix_sel = 1'b1; n_state = S_M2_LH;
            end
            S_M2_LH: begin
                o_cmd.op = OP_MUL_LH; o_cmd.mix_sel = 1'b1; n_state = S_M2_FIN;
            end
            S_M2_FIN: begin
                o_cmd.op = OP_MUL_FIN; o_cmd.mix_sel = 1'b1; n_state = S_XS31;
            end
            S_XS31:   begin o_cmd.op = OP_XS31;     n_state = S_MIXED; end
            S_MIXED: begin
                if (r_is_base) begin
                    o_cmd.op = OP_SAVE_BASE;
                    if (i_status.k_zero)      n_state = S_IDLE;
                    else if (i_status.d_zero) n_state = S_EMIT;
                    else                      n_state = S_PLOAD;
                end else begin
                    n_state = S_SC_HI;
                end
            end
            S_PLOAD: begin
                o_cmd.op  = OP_LOAD_PROJ;
                n_is_base = 1'b0;
                n_state   = S_ADDG;
            end
            S_SC_HI: begin o_cmd.op = OP_SCALE_HI; n_state = S_SC_LO; end
            S_SC_LO: begin o_cmd.op = OP_SCALE_LO; n_state = S_SC_FIN; end
            S_SC_FIN: begin
                o_cmd.op = OP_SCALE_FIN;
                n_state  = (i_status.uniq_mode && !i_status.t_zero) ? S_PINIT : S_EMIT;
            end
            S_PINIT: begin o_cmd.op = OP_PROBE_INIT; n_state = S_PRD; end
            S_PRD:   begin o_cmd.op = OP_PROBE_READ; n_state = S_PCMP; end
            S_PCMP: begin
                if (i_status.att_done) begin
                    n_state = S_EMIT;
                end else if (i_status.hit) begin
                    o_cmd.op = OP_PROBE_BUMP;
                    n_state  = S_PRD;
                end else if (i_status.probe_last) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_PROBE_NEXT;
                    n_state  = S_PRD;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (i_status.proj_last)   n_state = S_IDLE;
                    else if (i_status.d_zero) n_state = S_EMIT;
                    else                      n_state = S_PLOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/hpig_dp.sv]
// Datapath for the hashed projection index generator.
// Config registers, hash registers, 32x32 multiplier, chosen-index memory,
// output register. Depends on hpig_pkg.
module hpig_dp import hpig_pkg::*; #(
    parameter int MAX_PROJECTIONS = 16,
    parameter int MAX_DIM         = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic [63:0]       i_key,
    input  t_cmd              i_cmd,
    input  logic              i_out_stall,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [15:0]       o_index,
    output logic signed [1:0] o_sign,
    output logic              o_last
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int KW = $clog2(MAX_PROJECTIONS + 1);
    localparam int AW = (MAX_PROJECTIONS > 1) ? $clog2(MAX_PROJECTIONS) : 1;

    logic [16:0] r_dim;
    logic [63:0] r_seed;
    logic [4:0]  r_proj;
    logic        r_unique;

    logic [63:0] r_z, r_acc, r_prod, r_ctr;
    logic [DW-1:0] r_idx, r_att;
    logic          r_hsign;
    logic [KW-1:0] r_t, r_j;
    logic [15:0]   r_rd;

    logic [15:0] mem [MAX_PROJECTIONS];

    logic [31:0] dim32, proj32;
    logic [DW-1:0] d;
    logic [KW-1:0] k;
    logic [63:0] mix_c, mid, idx64;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [DW-1:0] idx_inc;

    assign dim32  = 32'(r_dim);
    assign proj32 = 32'(r_proj);
    assign d = DW'((dim32 > MAX_DIM) ? MAX_DIM : dim32);
    assign k = KW'((proj32 > MAX_PROJECTIONS) ? MAX_PROJECTIONS : proj32);

    assign mix_c = i_cmd.mix_sel ? MIX2 : MIX1;

    always_comb begin
        mul_a = r_z[31:0];
        mul_b = mix_c[31:0];
        case (i_cmd.op)
            OP_MUL_HL:   begin mul_a = r_z[63:32]; mul_b = mix_c[31:0];  end
            OP_MUL_LH:   begin mul_a = r_z[31:0];  mul_b = mix_c[63:32]; end
            OP_SCALE_HI: begin mul_a = r_z[63:32]; mul_b = 32'(d);       end
            OP_SCALE_LO: begin mul_a = r_z[31:0];  mul_b = 32'(d);       end
            default:     begin mul_a = r_z[31:0];  mul_b = mix_c[31:0];  end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mid     = r_acc + {32'd0, r_prod[63:32]};
    assign idx64   = 64'(r_idx);
    assign idx_inc = (r_idx + DW'(1) == d) ? '0 : r_idx + DW'(1);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim    <= 17'd1024;
            r_seed   <= '0;
            r_proj   <= 5'd1;
            r_unique <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DIM:    r_dim    <= i_cfg_data[16:0];
                REG_SEED:   r_seed   <= i_cfg_data;
                REG_PROJ:   r_proj   <= i_cfg_data[4:0];
                REG_UNIQUE: r_unique <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // hash, scale and probe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_t   <= '0;
        end else begin
            r_prod <= mul_p;
            case (i_cmd.op)
                OP_LOAD_KEY:  r_z <= i_key ^ KEY_SALT ^ (r_seed + GOLDEN);
                OP_ADD_GOLD:  r_z <= r_z + GOLDEN;
                OP_XS30:      r_z <= r_z ^ (r_z >> 30);
                OP_XS27:      r_z <= r_z ^ (r_z >> 27);
                OP_XS31:      r_z <= r_z ^ (r_z >> 31);
                OP_MUL_HL:    r_acc <= r_prod;
                OP_MUL_LH:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                OP_MUL_FIN:   r_z <= r_acc + {r_prod[31:0], 32'd0};
                OP_SAVE_BASE: begin
                    r_ctr <= r_z;
                    r_t   <= '0;
                end
                OP_LOAD_PROJ: r_z <= r_ctr;
                OP_SCALE_LO:  r_acc <= r_prod;
                OP_SCALE_FIN: begin
                    r_idx   <= mid[32+DW-1:32];
                    r_hsign <= r_z[0];
                end
                OP_PROBE_INIT: begin
                    r_j   <= '0;
                    r_att <= '0;
                end
                OP_PROBE_READ: r_rd <= mem[r_j[AW-1:0]];
                OP_PROBE_BUMP: begin
                    r_idx <= idx_inc;
                    r_att <= r_att + DW'(1);
                    r_j   <= '0;
                end
                OP_PROBE_NEXT: r_j <= r_j + KW'(1);
                OP_EMIT: begin
                    r_t   <= r_t + KW'(1);
                    r_ctr <= r_ctr + GOLDEN;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            mem[r_t[AW-1:0]] <= (d == '0) ? 16'd0 : idx64[15:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            o_out_valid <= 1'b1;
            o_index     <= (d == '0) ? 16'd0 : idx64[15:0];
            o_sign      <= (d == '0) ? SIGN_ZERO : (r_hsign ? SIGN_POS : SIGN_NEG);
            o_last      <= (r_t + KW'(1) == k);
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    assign o_status.hit        = (64'(r_rd) == idx64);
    assign o_status.probe_last = (r_j + KW'(1) == r_t);
    assign o_status.att_done   = (r_att == d);
    assign o_status.proj_last  = (r_t + KW'(1) == k);
    assign o_status.t_zero     = (r_t == '0);
    assign o_status.k_zero     = (k == '0);
    assign o_status.d_zero     = (d == '0);
    assign o_status.uniq_mode  = r_unique;
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

    a_sign_zero_iff_dim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sign == SIGN_ZERO) == (d == '0)))
        else $error("sign zero does not match zero dim");

    a_index_below_dim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && d != '0) |-> (32'(o_index) < 32'(d)))
        else $error("index out of range");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |-> (r_t < k))
        else $error("projection count past limit");

    a_emit_needs_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |-> o_status.out_free)
        else $error("result written over a waiting beat");

endmodule

[rtl/hashed_projection_index_generator.sv]
// Top level of the hashed projection index generator.
// Joins hpig_ctrl and hpig_dp; depends on hpig_pkg.
//
// Usage: one 64-bit key beat in (i_in_valid / o_in_stall) yields a run of
// index/sign beats out (o_out_valid / i_out_stall), o_last on the final one.
// Register writes (i_cfg_valid / o_cfg_ready, index 0 dim, 1 seed,
// 2 projections, 3 unique_mode) go in while no key is in flight; o_cfg_ready
// is low while a key is worked or a result beat waits.
// Sequence: the base hash is worked first; each result then runs its own hash and
// scaling plus, in unique mode, a compare against each earlier index of
// the key (a collision restarts the scan one index further). All of it runs
// through one shared 32x32 multiplier, three products per 64-bit multiply.
// With dim zero the results follow the base hash with no hash of their own.
// One key is worked at a time; o_in_stall is high until the last beat of
// the run is loaded into the output register, which holds while
// i_out_stall is high and the sequence waits on it.
// Reset: dim 1024, seed 0, projections 1, unique_mode 0, nothing in flight.
module hashed_projection_index_generator import hpig_pkg::*; #(
    parameter int MAX_PROJECTIONS = 16,
    parameter int MAX_DIM         = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [63:0]       i_key,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [15:0]       o_index,
    output logic signed [1:0] o_sign,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    busy;

    hpig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    hpig_dp #(
        .MAX_PROJECTIONS (MAX_PROJECTIONS),
        .MAX_DIM         (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key       (i_key),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_index     (o_index),
        .o_sign      (o_sign),
        .o_last      (o_last)
    );

    assign o_in_stall  = busy;
    assign o_cfg_ready = !busy && !o_out_valid;

endmodule

[sim/hashed_projection_index_generator_test.sv]
// Testbench for hashed_projection_index_generator: random keys and register settings,
// checked beat by beat against a built-in projection predictor.
// Depends on hpig_pkg and the block's RTL.
`timescale 1ns / 100ps

module hashed_projection_index_generator_test;
    import hpig_pkg::*;

    typedef struct {
        logic [15:0] index;
        logic [1:0]  sign;
        logic        last;
    } t_proj_beat;

    class projection_scoreboard;
        logic [16:0] dim_q;
        logic [63:0] seed_q;
        logic [4:0]  proj_q;
        logic        uniq_q;
        t_proj_beat  expected_beats[$];
        int          mismatches;

        function new();
            dim_q = 17'd1024;
            seed_q = '0;
            proj_q = 5'd1;
            uniq_q = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [63:0] data);
            case (idx)
                REG_DIM: dim_q = data[16:0];
                REG_SEED: seed_q = data;
                REG_PROJ: proj_q = data[4:0];
                REG_UNIQUE: uniq_q = data[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] splitmix(logic [63:0] x);
            logic [63:0] z;
            z = x + GOLDEN;
            z = (z ^ (z >> 30)) * MIX1;
            z = (z ^ (z >> 27)) * MIX2;
            return z ^ (z >> 31);
        endfunction

        // expand one accepted key into its run of index/sign beats
        function void note_key(logic [63:0] key);
            logic [63:0] base, h;
            logic [80:0] prod;
            logic [15:0] picked[16];
            int d, k, idx, attempts;
            bit taken;
            t_proj_beat b;
            d = (dim_q > 17'd65536) ? 65536 : int'(dim_q);
            k = (proj_q > 5'd16) ? 16 : int'(proj_q);
            base = splitmix(key ^ KEY_SALT ^ (seed_q + GOLDEN));
            for (int t = 0; t < k; t++) begin
                idx = 0;
                b.sign = SIGN_ZERO;
                if (d != 0) begin
                    h = splitmix(base + 64'(t) * GOLDEN);
                    prod = {17'b0, h} * {64'b0, 17'(d)};
                    idx = int'(prod[79:64]);
                    b.sign = h[0] ? SIGN_POS : SIGN_NEG;
                    if (uniq_q) begin
                        attempts = 0;
                        forever begin
                            taken = 0;
                            for (int j = 0; j < t; j++)
                                if (picked[j] == 16'(idx)) taken = 1;
                            if (attempts >= d || !taken) break;
                            idx = (idx + 1 == d) ? 0 : idx + 1;
                            attempts++;
                        end
                    end
                end
                picked[t] = 16'(idx);
                b.index = 16'(idx);
                b.last = (t + 1 == k);
                expected_beats.push_back(b);
            end
        endfunction

        function void check_beat(logic [15:0] index, logic [1:0] sign, logic last);
            t_proj_beat e;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: index %0d sign %b last %b", index, sign, last);
                return;
            end
            e = expected_beats.pop_front();
            if (e.index !== index || e.sign !== sign || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected index %0d sign %b last %b, got %0d %b %b",
                             e.index, e.sign, e.last, index, sign, last);
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    logic [63:0]       i_key = '0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    logic [15:0]       o_index;
    logic signed [1:0] o_sign;
    logic              o_last;
    logic              i_cfg_valid = 0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [63:0]       i_cfg_data = '0;

    projection_scoreboard sb = new();
    int  beats_out = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  held_off = 0;

    hashed_projection_index_generator dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // monitor: everything is sampled at the rising edge
    always @(posedge i_clk) begin
        bit any_beat;
        any_beat = 0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_key(i_key);
                any_beat = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_beat(o_index, o_sign, o_last);
                beats_out <= beats_out + 1;
                any_beat = 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                any_beat = 1;
            end
            idle_cycles <= any_beat ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= 4000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern; one long hold-off once the output has been busy a while
    always @(negedge i_clk) begin
        int hold, pct;
        if (!held_off && beats_out >= 150) begin
            held_off = 1;
            for (hold = 0; hold < 400; hold++) begin
                i_out_stall <= 1;
                @(negedge i_clk);
            end
        end
        pct = ((beats_out / 40) % 3) * 35;
        i_out_stall <= ($urandom_range(99, 0) < pct);
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] data);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic send_key(logic [63:0] key);
        int gap;
        i_in_valid = 1;
        i_key = key;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 1);
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_in_valid = 0;
                repeat (gap) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // keys with no results may still be hashing after the queue empties
    task automatic drain();
        i_in_valid = 0;
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic setup(logic [16:0] d, logic [63:0] s, logic [4:0] k, logic u);
        write_reg(REG_DIM, 64'(d));
        write_reg(REG_SEED, s);
        write_reg(REG_PROJ, 64'(k));
        write_reg(REG_UNIQUE, 64'(u));
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [16:0] d;
        logic [63:0] prev_key;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset defaults, key extremes
        send_key(64'h0);
        send_key('1);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'h5555_AAAA_5555_AAAA);
        drain();
        // zero dim
        setup(17'd0, 64'h1234, 5'd3, 1'b0);
        send_key(64'h1);
        send_key(64'hDEADBEEFF00DBABE);
        drain();
        // zero projections, stray register index ignored
        setup(17'd100, 64'h0, 5'd0, 1'b1);
        write_reg(8'd7, 64'hFFFF);
        send_key(64'h42);
        send_key('1);
        drain();
        // unique with more projections than dim
        setup(17'd1, '1, 5'd16, 1'b1);
        send_key(64'h7);
        drain();
        setup(17'd5, 64'h99, 5'd16, 1'b1);
        send_key(64'h0);
        send_key(64'hFFFF_0000_FFFF_0000);
        drain();
        // saturated dim and projections
        setup(17'h1FFFF, '1, 5'd31, 1'b1);
        send_key(64'h3);
        send_key('1);
        drain();
        setup(17'd65536, 64'h0, 5'd16, 1'b0);
        send_key(64'hA5A5_A5A5_A5A5_A5A5);
        send_key(64'h0);
        drain();

        prev_key = '0;
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(3, 0))
                0: d = 17'($urandom_range(20, 1));
                1: d = 17'($urandom);
                2: d = 17'($urandom_range(300, 2));
                default: d = (ph == 5) ? 17'd0 : 17'($urandom_range(65536, 60000));
            endcase
            setup(d, rand_key(),
                  ($urandom_range(5, 0) == 0) ? 5'($urandom) : 5'($urandom_range(16, 1)),
                  1'($urandom));
            for (int n = 0; n < 32; n++) begin
                if ($urandom_range(7, 0) == 0) send_key(prev_key);
                else begin
                    prev_key = rand_key();
                    send_key(prev_key);
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/hpig_pkg.sv
rtl/hpig_ctrl.sv
rtl/hpig_dp.sv
rtl/hashed_projection_index_generator.sv
sim/hashed_projection_index_generator_test.sv
